FILE: rtl/core/wcs_pkg.sv
package wcs_pkg;

    // Fixed field widths of the stream words
    localparam int COORD_IN_W = 16;
    localparam int WIN_W      = 16;
    localparam int IDX_OUT_W  = 6;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd160;

    // Request kinds carried on the slave-side tuser
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic                 found;
        logic                 last;
        logic                 full;
    } t_result;

endpackage

FILE: rtl/core/wcs_ram.sv
module wcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/wcs_outreg.sv
module wcs_outreg
    import wcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_vld;
    t_result r_res;

    // A new word may be loaded when the register is empty or is emptied this cycle.
    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: rtl/core/wcs_ctrl.sv
module wcs_ctrl
    import wcs_pkg::*;
#(
    parameter int POOL_SIZE = 64,
    parameter int CW        = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_req,
    input  logic [CW-1:0]                i_x,
    input  logic [CW-1:0]                i_y,
    input  logic [WIN_W-1:0]             i_window,
    input  logic                         i_out_free,
    output logic                         o_push,
    output t_result                      o_res,
    output logic                         o_ram_we,
    output logic [$clog2(POOL_SIZE)-1:0] o_ram_waddr,
    output logic [2*CW-1:0]              o_ram_wdata,
    output logic                         o_ram_re,
    output logic [$clog2(POOL_SIZE)-1:0] o_ram_raddr,
    input  logic [2*CW-1:0]              i_ram_rdata
);

    localparam int IW   = $clog2(POOL_SIZE);
    localparam int CNTW = $clog2(POOL_SIZE + 1);
    localparam int CMPW = (CW + 1 > WIN_W) ? CW + 1 : WIN_W;
    localparam logic [CNTW-1:0] POOL_MAX = CNTW'(POOL_SIZE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state               r_state;
    logic [CNTW-1:0]      r_count;
    logic [POOL_SIZE-1:0] r_union;
    logic                 r_finish;
    logic                 r_ack_full;
    logic                 r_rd_more;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_b_vld;
    logic [IW-1:0]        r_b_idx;
    logic                 r_pend_vld;
    logic [IW-1:0]        r_pend_idx;
    logic [CW-1:0]        r_qx;
    logic [CW-1:0]        r_qy;

    logic [CW-1:0]   pool_x;
    logic [CW-1:0]   pool_y;
    logic [CW-1:0]   dx;
    logic [CW-1:0]   dy;
    logic            b_hit;
    logic            has_room;
    logic [CNTW-1:0] limit;
    logic [CNTW:0]   rd_next;
    logic            cand;
    t_result         res;

    assign pool_x = i_ram_rdata[CW-1:0];
    assign pool_y = i_ram_rdata[2*CW-1:CW];
    assign dx     = (pool_x >= r_qx) ? pool_x - r_qx : r_qx - pool_x;
    assign dy     = (pool_y >= r_qy) ? pool_y - r_qy : r_qy - pool_y;

    // Doubling the distance stands in for halving the window, so the test is exact.
    always_comb begin
        if (r_finish) begin
            b_hit = r_union[r_b_idx];
        end else begin
            b_hit = (CMPW'({dx, 1'b0}) <= CMPW'(i_window))
                 && (CMPW'({dy, 1'b0}) <= CMPW'(i_window));
        end
    end

    assign has_room = r_count < POOL_MAX;
    assign limit    = r_finish ? POOL_MAX : r_count;
    assign rd_next  = (CNTW + 1)'(r_rd_idx) + 1'b1;

    // A finish walks the union only, so the pool memory is left unread.
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_ram_we    = (r_state == ST_IDLE) && i_in_valid && (i_req == REQ_LOAD) && has_room;
    assign o_ram_waddr = r_count[IW-1:0];
    assign o_ram_wdata = {i_y, i_x};
    assign o_ram_re    = (r_state == ST_SCAN) && r_rd_more && i_out_free && !r_finish;
    assign o_ram_raddr = r_rd_idx;

    // A hit is held back until the next hit or the end of the scan shows whether it is the last.
    always_comb begin
        cand  = 1'b0;
        res   = '0;
        unique case (r_state)
            ST_ACK: begin
                cand     = 1'b1;
                res.last = 1'b1;
                res.full = r_ack_full;
            end
            ST_SCAN: begin
                cand      = r_b_vld && b_hit && r_pend_vld;
                res.idx   = IDX_OUT_W'(r_pend_idx);
                res.found = 1'b1;
            end
            ST_FLUSH: begin
                cand      = 1'b1;
                res.idx   = r_pend_vld ? IDX_OUT_W'(r_pend_idx) : '0;
                res.found = r_pend_vld;
                res.last  = 1'b1;
            end
            default: begin
                cand = 1'b0;
            end
        endcase
    end

    assign o_push = cand && i_out_free;
    assign o_res  = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_union    <= '0;
            r_finish   <= 1'b0;
            r_rd_more  <= 1'b0;
            r_rd_idx   <= '0;
            r_b_vld    <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_qx       <= i_x;
                        r_qy       <= i_y;
                        r_rd_idx   <= '0;
                        r_b_vld    <= 1'b0;
                        r_pend_vld <= 1'b0;
                        unique case (i_req)
                            REQ_LOAD: begin
                                r_ack_full <= !has_room;
                                if (has_room) begin
                                    r_count <= r_count + 1'b1;
                                end
                                r_state <= ST_ACK;
                            end
                            REQ_QUERY: begin
                                r_finish  <= 1'b0;
                                r_rd_more <= (r_count != '0);
                                r_state   <= ST_SCAN;
                            end
                            REQ_FINISH: begin
                                r_finish  <= 1'b1;
                                r_rd_more <= 1'b1;
                                r_state   <= ST_SCAN;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_ACK: begin
                    if (i_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (i_out_free) begin
                        if (r_rd_more) begin
                            r_rd_idx  <= r_rd_idx + 1'b1;
                            r_b_vld   <= 1'b1;
                            r_b_idx   <= r_rd_idx;
                            r_rd_more <= rd_next < (CNTW + 1)'(limit);
                        end else begin
                            r_b_vld <= 1'b0;
                        end
                        if (r_b_vld && b_hit) begin
                            r_pend_vld <= 1'b1;
                            r_pend_idx <= r_b_idx;
                            if (!r_finish) begin
                                r_union[r_b_idx] <= 1'b1;
                            end
                        end
                        if (!r_rd_more && !r_b_vld) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (i_out_free) begin
                        r_pend_vld <= 1'b0;
                        r_state    <= ST_IDLE;
                        if (r_finish) begin
                            r_count <= '0;
                            r_union <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= POOL_MAX)
        else $error("pool count beyond pool size");

    a_scan_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && o_push) |-> (!o_res.last && o_res.found))
        else $error("a held hit went out marked last during the scan");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_finish && i_out_free) |=> (r_count == '0 && r_union == '0))
        else $error("pool or union not cleared after finish");

    a_stage_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld || o_ram_re) |-> (r_state == ST_SCAN))
        else $error("scan pipeline active outside a scan");

endmodule

FILE: rtl/core/window_candidate_search.sv
// A load request enters an acknowledge state, which pushes the acknowledgement word into the
// output register once it is free. A query reads the pool memory one entry a cycle while the
// output side is free, testing each entry as its data returns; a finish walks the union bits.
// Throughput is one request at a time; a stalled master side stalls the scan.
// Reset is synchronous: it empties the pool, clears the union and sets the window to 160.
// The pool memory itself is not cleared; only entries below the pool count are ever read.
module window_candidate_search
    import wcs_pkg::*;
#(
    parameter int POOL_SIZE  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_window_size_we,
    input  logic [WIN_W-1:0] i_window_size,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // x_coord [15:0], y_coord [31:16]
    input  logic [1:0]       s_axis_tuser,   // req_type [1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // cand_index [5:0], zeros [7:6]
    output logic [1:0]       m_axis_tuser,   // found [0], pool_full [1]
    output logic             m_axis_tlast
);

    localparam int CW = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
    localparam int AW = $clog2(POOL_SIZE);

    logic [WIN_W-1:0] r_window;
    logic             out_free;
    logic             push;
    t_result          res;
    t_result          out_res;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [2*CW-1:0]  ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [2*CW-1:0]  ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_window_size_we) begin
            r_window <= i_window_size;
        end
    end

    wcs_ram #(
        .WIDTH (2 * CW),
        .DEPTH (POOL_SIZE)
    ) u_pool_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    wcs_ctrl #(
        .POOL_SIZE (POOL_SIZE),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req       (s_axis_tuser),
        .i_x         (s_axis_tdata[CW-1:0]),
        .i_y         (s_axis_tdata[COORD_IN_W +: CW]),
        .i_window    (r_window),
        .i_out_free  (out_free),
        .o_push      (push),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    wcs_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.idx};
    assign m_axis_tuser = {out_res.full, out_res.found};
    assign m_axis_tlast = out_res.last;

endmodule
